// ----- rtl/core/rkvs_pkg.sv -----
// Package of the verified Rabin-Karp search block.
// Holds the sequencer state type, the operation codes of the shared unit
// and the fixed register indexes. No dependencies.
package rkvs_pkg;

	// Sequencer states.
	typedef enum logic [3:0] {
		S_IDLE,
		S_MUL,
		S_RED,
		S_SUB,
		S_WRITE,
		S_VRD,
		S_VCMP,
		S_LAST,
		S_EMIT
	} state_t;

	// Operations run on the shared multiply and reduce unit.
	typedef enum logic [1:0] {
		OP_NHASH,
		OP_NPOW,
		OP_WHASH,
		OP_WDROP
	} op_t;

	// Configuration register indexes.
	localparam logic REG_BASE    = 1'b0;
	localparam logic REG_MODULUS = 1'b1;

	localparam int HASH_W  = 31;
	localparam int INDEX_W = 32;
	localparam int PROD_W  = 2 * HASH_W + 1;

	localparam logic [HASH_W-1:0] BASE_RESET    = 31'd257;
	localparam logic [HASH_W-1:0] MODULUS_RESET = 31'd1000000007;
	localparam logic [HASH_W-1:0] MODULUS_MIN   = 31'd2;

endpackage

// ----- rtl/core/rkvs_if.sv -----
// Channel interfaces of the verified Rabin-Karp search block.
// One interface for input bytes, one for results. Uses no package.
interface rkvs_in_if;
	logic       valid;
	logic       ready;
	logic       action;
	logic [7:0] data_byte;
	logic       first_byte;
	logic       last_byte;

	modport source (output valid, action, data_byte, first_byte, last_byte, input ready);
	modport sink (input valid, action, data_byte, first_byte, last_byte, output ready);
endinterface

interface rkvs_out_if;
	logic        valid;
	logic        ready;
	logic        found;
	logic [31:0] match_start;
	logic        bad_needle;

	modport source (output valid, found, match_start, bad_needle, input ready);
	modport sink (input valid, found, match_start, bad_needle, output ready);
endinterface

// ----- rtl/core/rabin_karp_verified_search.sv -----
// Verified Rabin-Karp search. A needle byte takes two products (hash and power), a haystack
// byte one, or two and a subtract once the window is full, plus a byte-by-byte compare on a
// hash hit; one shared 31x31 multiplier and a one-bit-per-cycle modular reduction do the work.
// One item at a time.
// A result leaves through an output register. Reset (arst_n low) clears the sequencer and the
// running hashes at once; the working registers and the needle and window memories are not cleared.
module rabin_karp_verified_search
	import rkvs_pkg::*;
#(
	parameter int MAX_NEEDLE = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic              cfg_index,
	input  logic [HASH_W-1:0] cfg_data,
	rkvs_in_if.sink           din,
	rkvs_out_if.source        dout
);
	localparam int PW = (MAX_NEEDLE > 1) ? $clog2(MAX_NEEDLE) : 1;
	localparam int LW = $clog2(MAX_NEEDLE + 1);
	localparam int DW = PW + 2;
	localparam int CW = $clog2(PROD_W);
	localparam logic [LW-1:0] LEN_MAX = LW'(MAX_NEEDLE);
	localparam logic [PW-1:0] POS_LAST = PW'(MAX_NEEDLE - 1);

	state_t state_q, state_d;
	op_t    op_q;

	logic [HASH_W-1:0]  base_q, mod_q, m_eff;
	logic [HASH_W-1:0]  nh_q, dp_q, wh_q, h_q, term_q, rem_q;
	logic [LW-1:0]      len_q, len_eff, k_q;
	logic               ovf_q, rg_q, rg_eff, last_q;
	logic [7:0]         byte_q;
	logic [INDEX_W-1:0] i_q;
	logic [PW-1:0]      wpos_q, p_q, old_pos, start_pos;
	logic [PROD_W-1:0]  prod_q;
	logic [CW-1:0]      cnt_q;
	logic               res_found_q, res_bad_q;
	logic [INDEX_W-1:0] res_start_q;
	logic               ovld_q, ofound_q, obad_q;
	logic [INDEX_W-1:0] ostart_q;

	logic                accept, emit_go;
	logic                n_we, r_we;
	logic [PW-1:0]       n_waddr, n_raddr, r_raddr;
	logic [7:0]          n_rdata, r_rdata;
	logic [HASH_W-1:0]   opa, opb;
	logic [7:0]          opc;
	logic [2*HASH_W-1:0] mul_p;
	logic [HASH_W:0]     rem_sh, rem_nx, sub_sum;
	logic [DW-1:0]       pos_diff, pos_wrap;
	logic                hit, same;

	assign m_eff   = (mod_q < MODULUS_MIN) ? MODULUS_MIN : mod_q;
	assign accept  = din.valid && din.ready;
	assign len_eff = din.first_byte ? '0 : len_q;
	assign rg_eff  = din.first_byte ? 1'b0 : rg_q;
	assign emit_go = !ovld_q || dout.ready;

	// Ring positions of the leaving byte and of the window start.
	assign pos_diff  = DW'(wpos_q) - DW'(len_q);
	assign pos_wrap  = pos_diff[DW-1] ? pos_diff + DW'(MAX_NEEDLE) : pos_diff;
	assign old_pos   = pos_wrap[PW-1:0];
	assign start_pos = (old_pos == POS_LAST) ? '0 : old_pos + PW'(1);

	// Operand selection for the shared multiplier.
	always_comb begin
		case (op_q)
			OP_NHASH: begin opa = nh_q; opb = base_q; opc = byte_q; end
			OP_NPOW:  begin opa = dp_q; opb = base_q; opc = 8'd0; end
			OP_WHASH: begin opa = wh_q; opb = base_q; opc = byte_q; end
			OP_WDROP: begin opa = dp_q; opb = HASH_W'(r_rdata); opc = 8'd0; end
			default:  begin opa = '0; opb = '0; opc = 8'd0; end
		endcase
	end

	// Full-width product of the shared multiplier.
	assign mul_p = opa * opb;

	// One restoring reduction step, and the final subtract of the leaving term.
	assign rem_sh  = {rem_q, prod_q[PROD_W-1]};
	assign rem_nx  = (rem_sh >= {1'b0, m_eff}) ? rem_sh - {1'b0, m_eff} : rem_sh;
	assign sub_sum = {1'b0, h_q} + {1'b0, m_eff} - {1'b0, term_q};
	assign hit     = (i_q >= INDEX_W'(len_q) - INDEX_W'(1)) && (h_q == nh_q);
	assign same    = (n_rdata == r_rdata);

	// Next-state logic.
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (din.valid) begin
					if (!din.action) begin
						state_d = (len_eff < LEN_MAX) ? S_MUL : S_IDLE;
					end else if (rg_eff) begin
						state_d = S_IDLE;
					end else if (len_q == '0 || (ovf_q && !din.first_byte) ||
					             (ovf_q && din.first_byte)) begin
						state_d = S_EMIT;
					end else begin
						state_d = S_MUL;
					end
				end
			end
			S_MUL: state_d = S_RED;
			S_RED: begin
				if (cnt_q == '0) begin
					case (op_q)
						OP_NHASH: state_d = S_MUL;
						OP_NPOW:  state_d = S_IDLE;
						OP_WHASH: state_d = (i_q >= INDEX_W'(len_q)) ? S_MUL : S_WRITE;
						default:  state_d = S_SUB;
					endcase
				end
			end
			S_SUB:   state_d = S_WRITE;
			S_WRITE: state_d = hit ? S_VRD : S_LAST;
			S_VRD:   state_d = S_VCMP;
			S_VCMP: begin
				if (!same) begin
					state_d = S_LAST;
				end else if (k_q == len_q - LW'(1)) begin
					state_d = S_EMIT;
				end else begin
					state_d = S_VRD;
				end
			end
			S_LAST: state_d = last_q ? S_EMIT : S_IDLE;
			S_EMIT: state_d = emit_go ? S_IDLE : S_EMIT;
			default: state_d = S_IDLE;
		endcase
	end

	// Handshake and memory port control.
	always_comb begin
		din.ready = (state_q == S_IDLE);
		n_we      = accept && !din.action && (len_eff < LEN_MAX);
		n_waddr   = len_eff[PW-1:0];
		n_raddr   = k_q[PW-1:0];
		r_we      = (state_q == S_WRITE);
		r_raddr   = (state_q == S_VRD) ? p_q : old_pos;
	end

	rkvs_ram #(.WIDTH(8), .DEPTH(MAX_NEEDLE)) u_needle (
		.clk   (clk),
		.we    (n_we),
		.waddr (n_waddr),
		.wdata (din.data_byte),
		.raddr (n_raddr),
		.rdata (n_rdata)
	);

	rkvs_ram #(.WIDTH(8), .DEPTH(MAX_NEEDLE)) u_ring (
		.clk   (clk),
		.we    (r_we),
		.waddr (wpos_q),
		.wdata (byte_q),
		.raddr (r_raddr),
		.rdata (r_rdata)
	);

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= BASE_RESET;
			mod_q  <= MODULUS_RESET;
		end else if (cfg_we) begin
			if (cfg_index == REG_BASE) begin
				base_q <= cfg_data;
			end else if (cfg_index == REG_MODULUS) begin
				mod_q <= cfg_data;
			end
		end
	end

	// Sequencer and search state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			op_q        <= OP_NHASH;
			len_q       <= '0;
			ovf_q       <= 1'b0;
			nh_q        <= '0;
			dp_q        <= HASH_W'(1);
			wh_q        <= '0;
			i_q         <= '0;
			wpos_q      <= '0;
			rg_q        <= 1'b0;
			rem_q       <= '0;
			cnt_q       <= '0;
			k_q         <= '0;
			res_found_q <= 1'b0;
			res_bad_q   <= 1'b0;
			res_start_q <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (!din.action) begin
							op_q <= OP_NHASH;
							if (din.first_byte) begin
								len_q <= '0;
								ovf_q <= 1'b0;
								nh_q  <= '0;
								dp_q  <= HASH_W'(1);
							end else if (len_q >= LEN_MAX) begin
								ovf_q <= 1'b1;
							end
						end else begin
							op_q <= OP_WHASH;
							if (din.first_byte) begin
								i_q    <= '0;
								wpos_q <= '0;
								wh_q   <= '0;
								rg_q   <= 1'b0;
							end
							res_found_q <= 1'b0;
							res_bad_q   <= 1'b1;
							res_start_q <= '0;
						end
					end
				end
				S_MUL: begin
					rem_q <= '0;
					cnt_q <= CW'(PROD_W - 1);
				end
				S_RED: begin
					rem_q <= rem_nx[HASH_W-1:0];
					cnt_q <= cnt_q - CW'(1);
					if (cnt_q == '0) begin
						case (op_q)
							OP_NHASH: begin
								nh_q <= rem_nx[HASH_W-1:0];
								op_q <= OP_NPOW;
							end
							OP_NPOW: begin
								dp_q  <= rem_nx[HASH_W-1:0];
								len_q <= len_q + LW'(1);
							end
							OP_WHASH: begin
								op_q <= OP_WDROP;
							end
							default: ;
						endcase
					end
				end
				S_WRITE: begin
					wh_q   <= h_q;
					i_q    <= i_q + INDEX_W'(1);
					wpos_q <= (wpos_q == POS_LAST || i_q == '1) ? '0 : wpos_q + PW'(1);
					k_q    <= '0;
					res_found_q <= 1'b1;
					res_bad_q   <= 1'b0;
					res_start_q <= i_q - INDEX_W'(len_q) + INDEX_W'(1);
				end
				S_VCMP: begin
					k_q <= k_q + LW'(1);
				end
				S_LAST: begin
					res_found_q <= 1'b0;
					res_bad_q   <= 1'b0;
					res_start_q <= '0;
				end
				S_EMIT: begin
					if (emit_go) begin
						rg_q <= 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	// Payload registers of the shared unit and the compare walk.
	always_ff @(posedge clk) begin
		if (accept) begin
			byte_q <= din.data_byte;
			last_q <= din.last_byte;
		end
		case (state_q)
			S_MUL: prod_q <= PROD_W'(mul_p) + PROD_W'(opc);
			S_RED: begin
				prod_q <= {prod_q[PROD_W-2:0], 1'b0};
				if (cnt_q == '0) begin
					if (op_q == OP_WHASH) h_q <= rem_nx[HASH_W-1:0];
					if (op_q == OP_WDROP) term_q <= rem_nx[HASH_W-1:0];
				end
			end
			S_SUB: begin
				h_q <= (sub_sum >= {1'b0, m_eff}) ? HASH_W'(sub_sum - {1'b0, m_eff})
				                                  : sub_sum[HASH_W-1:0];
			end
			S_WRITE: p_q <= start_pos;
			S_VCMP:  p_q <= (p_q == POS_LAST) ? '0 : p_q + PW'(1);
			default: ;
		endcase
	end

	// Output register: a result waits here for its transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovld_q   <= 1'b0;
			ofound_q <= 1'b0;
			obad_q   <= 1'b0;
			ostart_q <= '0;
		end else if (state_q == S_EMIT && emit_go) begin
			ovld_q   <= 1'b1;
			ofound_q <= res_found_q;
			obad_q   <= res_bad_q;
			ostart_q <= res_start_q;
		end else if (dout.ready) begin
			ovld_q <= 1'b0;
		end
	end

	assign dout.valid       = ovld_q;
	assign dout.found       = ofound_q;
	assign dout.match_start = ostart_q;
	assign dout.bad_needle  = obad_q;

	// The running remainder stays below the modulus throughout a reduction.
	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RED) |-> (rem_q < m_eff))
		else $error("reduction remainder out of range");

	// The kept needle length never exceeds the store.
	a_len_range: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= LEN_MAX)
		else $error("needle length beyond store");

	// The compare walk stays inside the needle.
	a_walk_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_VCMP) |-> (k_q < len_q))
		else $error("compare index beyond needle");

	// A result is never shown as both found and bad needle.
	a_result_kind: assert property (@(posedge clk) disable iff (!arst_n)
		ovld_q |-> !(ofound_q && obad_q))
		else $error("conflicting result flags");
endmodule

// ----- rtl/core/rkvs_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// Used for the needle store and the window ring. No dependencies.
module rkvs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                                 clk,
	input  logic                                 we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                     wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                     rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ----- tb/rabin_karp_verified_search_tb.sv -----
// Testbench of the verified Rabin-Karp search block.
// Drives needle and haystack bytes, predicts every result and checks it.
// Depends on rkvs_pkg and the channel interfaces in rkvs_if.
`timescale 1ns / 1ps

module rabin_karp_verified_search_tb
	import rkvs_pkg::*;
();

	localparam logic ACT_LOAD = 1'b0;
	localparam logic ACT_SCAN = 1'b1;
	localparam int NEEDLE_CAP = 64;
	localparam int SETTLE_CYCLES = 400;
	localparam int HOLD_CYCLES = 600;
	localparam int STALL_LIMIT = 5000;
	localparam int RANDOM_ITEMS = 1450;

	typedef struct packed {
		logic        found;
		logic [31:0] match_start;
		logic        bad_needle;
	} search_result_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic cfg_index;
	logic [HASH_W-1:0] cfg_data;

	rkvs_in_if  din_ch ();
	rkvs_out_if dout_ch ();

	rabin_karp_verified_search dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.din(din_ch),
		.dout(dout_ch)
	);

	// Predicted search state.
	logic [HASH_W-1:0] base_r;
	logic [HASH_W-1:0] mod_r;
	logic [7:0] pat_mem [NEEDLE_CAP];
	logic [7:0] ring_mem [NEEDLE_CAP];
	int unsigned pat_len;
	bit pat_over;
	logic [HASH_W-1:0] pat_hash;
	logic [HASH_W-1:0] pat_pow;
	logic [HASH_W-1:0] win_hash;
	logic [31:0] pos_cnt;
	bit done_flag;

	search_result_t pending_results[$];
	int mismatches;
	bit tx_idle_on;
	bit rx_idle_on;
	bit rx_hold_req;
	int stall_count;
	int random_sent;
	logic [7:0] cur_pattern[$];

	// Clock.
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Applies one accepted byte to the predicted state.
	task automatic predict_search(input logic act, input logic [7:0] d, input logic f,
		input logic l);
		longint unsigned m;
		longint unsigned b;
		longint unsigned h;
		longint unsigned term;
		logic [31:0] i;
		logic [31:0] len;
		logic [31:0] start;
		bit same;
		search_result_t r;
		m = (mod_r < 2) ? 64'd2 : 64'(mod_r);
		b = 64'(base_r);
		if (act == ACT_LOAD) begin
			if (f) begin
				pat_len = 0;
				pat_over = 0;
				pat_hash = '0;
				pat_pow = 1;
			end
			if (pat_len < NEEDLE_CAP) begin
				pat_mem[pat_len] = d;
				pat_hash = HASH_W'((64'(pat_hash) * b + 64'(d)) % m);
				pat_pow = HASH_W'((64'(pat_pow) * b) % m);
				pat_len++;
			end else begin
				pat_over = 1;
			end
			return;
		end
		if (f) begin
			pos_cnt = '0;
			win_hash = '0;
			done_flag = 0;
		end
		if (done_flag) return;
		if (pat_len == 0 || pat_over) begin
			r = '{found: 1'b0, match_start: 32'd0, bad_needle: 1'b1};
			pending_results = {pending_results, r};
			done_flag = 1;
			return;
		end
		len = 32'(pat_len);
		i = pos_cnt;
		h = (64'(win_hash) * b + 64'(d)) % m;
		if (i >= len) begin
			term = (64'(pat_pow) * 64'(ring_mem[(i - len) % NEEDLE_CAP])) % m;
			h = (h + m - term) % m;
		end
		win_hash = HASH_W'(h);
		ring_mem[i % NEEDLE_CAP] = d;
		pos_cnt = i + 1;
		if (i >= len - 1 && win_hash == pat_hash) begin
			start = i - len + 1;
			same = 1;
			for (int k = 0; k < pat_len; k++) begin
				if (ring_mem[(start + 32'(k)) % NEEDLE_CAP] != pat_mem[k]) same = 0;
			end
			if (same) begin
				r = '{found: 1'b1, match_start: start, bad_needle: 1'b0};
				pending_results = {pending_results, r};
				done_flag = 1;
				return;
			end
		end
		if (l) begin
			r = '{found: 1'b0, match_start: 32'd0, bad_needle: 1'b0};
			pending_results = {pending_results, r};
			done_flag = 1;
		end
	endtask

	// Sends one byte; called at a falling edge, returns at a falling edge with valid high.
	task automatic send_byte(input logic act, input logic [7:0] d, input logic f,
		input logic l);
		int gap;
		gap = tx_idle_on ? $urandom_range(0, 14) : 0;
		if (gap > 0) begin
			din_ch.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		din_ch.valid = 1'b1;
		din_ch.action = act;
		din_ch.data_byte = d;
		din_ch.first_byte = f;
		din_ch.last_byte = l;
		do @(posedge clk); while (!din_ch.ready);
		predict_search(act, d, f, l);
		@(negedge clk);
	endtask

	// Waits until every expected result has arrived and the block has gone quiet.
	task automatic settle();
		din_ch.valid = 1'b0;
		while (pending_results.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [HASH_W-1:0] val);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		@(negedge clk);
		cfg_we = 1'b0;
		if (idx == REG_BASE) base_r = val;
		else mod_r = val;
	endtask

	task automatic load_pattern(input logic [7:0] p[$]);
		cur_pattern = p;
		foreach (p[k]) send_byte(ACT_LOAD, p[k], k == 0, 1'b0);
	endtask

	task automatic scan_text(input logic [7:0] t[$]);
		foreach (t[k]) send_byte(ACT_SCAN, t[k], k == 0, k == t.size() - 1);
	endtask

	// A scan of a haystack with no needle loaded yet gives a bad needle.
	task automatic test_empty_needle();
		scan_text('{8'h00, 8'hFF});
		send_byte(ACT_SCAN, 8'h55, 1'b0, 1'b1);
	endtask

	// Matches, a miss, extreme bytes and ignored bytes after a result.
	task automatic test_basic_search();
		load_pattern('{8'h00, 8'hFF});
		scan_text('{8'h12, 8'h00, 8'hFF, 8'h34});
		send_byte(ACT_SCAN, 8'h00, 1'b0, 1'b1);
		scan_text('{8'hFF, 8'h00, 8'hAA});
		load_pattern('{8'hA5});
		scan_text('{8'hA5});
	endtask

	// A needle longer than the store gives a bad needle; a full-size one still works.
	task automatic test_long_needle();
		logic [7:0] p[$];
		for (int k = 0; k < NEEDLE_CAP + 1; k++) p = {p, 8'(k)};
		load_pattern(p);
		scan_text('{8'h00, 8'h01});
		p.pop_back();
		load_pattern(p);
		scan_text(p);
	endtask

	// Tiny moduli force hash hits that the byte compare must reject.
	task automatic test_register_extremes();
		settle();
		write_reg(REG_MODULUS, 31'd0);
		write_reg(REG_BASE, 31'h7FFFFFFF);
		load_pattern('{8'h01, 8'h02});
		scan_text('{8'h02, 8'h01, 8'h03, 8'h01, 8'h02});
		settle();
		write_reg(REG_MODULUS, 31'd1);
		write_reg(REG_BASE, 31'd2);
		scan_text('{8'h01, 8'h01, 8'h01});
		settle();
		write_reg(REG_MODULUS, 31'h7FFFFFFF);
		write_reg(REG_BASE, 31'h7FFFFFFF);
		scan_text('{8'hFE, 8'h01, 8'h02});
		settle();
	endtask

	// The output is held off while the sender keeps offering one-byte searches.
	task automatic test_backpressure();
		load_pattern('{8'h3C});
		rx_hold_req = 1;
		for (int k = 0; k < 12; k++) send_byte(ACT_SCAN, (k % 2) ? 8'h3C : 8'hC3, 1'b1, 1'b1);
		settle();
	endtask

	function automatic logic [HASH_W-1:0] pick_base();
		case ($urandom_range(0, 3))
			0: return 31'd2;
			1: return 31'h7FFFFFFF;
			2: return BASE_RESET;
			default: return 31'($urandom());
		endcase
	endfunction

	function automatic logic [HASH_W-1:0] pick_modulus();
		case ($urandom_range(0, 5))
			0: return 31'($urandom_range(0, 3));
			1: return 31'($urandom_range(4, 60));
			2: return 31'h7FFFFFFF;
			3: return MODULUS_RESET;
			default: return 31'($urandom());
		endcase
	endfunction

	// Well-formed searches over a two-letter alphabet, with some noise.
	task automatic test_random_searches();
		logic [7:0] alpha[2];
		logic [7:0] p[$];
		logic [7:0] t[$];
		int plen;
		int tlen;
		int at;
		int phase_items;
		while (random_sent < RANDOM_ITEMS) begin
			settle();
			write_reg(REG_BASE, pick_base());
			write_reg(REG_MODULUS, pick_modulus());
			tx_idle_on = $urandom_range(0, 3) != 0;
			rx_idle_on = $urandom_range(0, 3) != 0;
			phase_items = 0;
			while (phase_items < 300 && random_sent + phase_items < RANDOM_ITEMS) begin
				alpha[0] = 8'($urandom());
				alpha[1] = 8'($urandom());
				if ($urandom_range(0, 9) == 0) begin
					// Noise: any fields at all.
					for (int k = 0; k < 8; k++)
						send_byte(1'($urandom()), 8'($urandom()), 1'($urandom()),
							1'($urandom()));
					phase_items += 8;
					continue;
				end
				case ($urandom_range(0, 19))
					0: plen = $urandom_range(NEEDLE_CAP + 1, NEEDLE_CAP + 4);
					1, 2: plen = $urandom_range(20, NEEDLE_CAP);
					default: plen = $urandom_range(1, 6);
				endcase
				p.delete();
				for (int k = 0; k < plen; k++) p = {p, alpha[$urandom_range(0, 1)]};
				load_pattern(p);
				tlen = (plen > 10) ? plen + $urandom_range(0, 10) : $urandom_range(1, 30);
				t.delete();
				for (int k = 0; k < tlen; k++) t = {t, alpha[$urandom_range(0, 1)]};
				if (plen <= tlen && $urandom_range(0, 1)) begin
					at = $urandom_range(0, tlen - plen);
					for (int k = 0; k < plen; k++) t[at + k] = p[k];
				end
				if ($urandom_range(0, 15) == 0 && tlen > 4) begin
					// A new needle arrives partway through the scan.
					at = tlen / 2;
					foreach (t[k]) begin
						if (k == at) begin
							send_byte(ACT_LOAD, alpha[0], 1'b1, 1'b0);
							send_byte(ACT_LOAD, alpha[1], 1'b0, 1'b0);
							phase_items += 2;
						end
						send_byte(ACT_SCAN, t[k], k == 0, k == tlen - 1);
					end
				end else begin
					scan_text(t);
				end
				phase_items += plen + tlen;
			end
			random_sent += phase_items;
		end
		settle();
	endtask

	// Receiver: draws a wait for each result, or holds off for a long stretch.
	initial begin
		int gap;
		dout_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (rx_hold_req) begin
				dout_ch.ready = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				rx_hold_req = 0;
			end
			gap = rx_idle_on ? $urandom_range(0, 14) : 0;
			dout_ch.ready = 1'b0;
			repeat (gap) @(negedge clk);
			dout_ch.ready = 1'b1;
			do @(posedge clk); while (!dout_ch.valid);
		end
	end

	// Result checker: each transfer is compared with the oldest expectation.
	always @(posedge clk) begin
		search_result_t want;
		if (arst_n && dout_ch.valid && dout_ch.ready) begin
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: found %0b start %0d bad %0b",
						dout_ch.found, dout_ch.match_start, dout_ch.bad_needle);
			end else begin
				want = pending_results.pop_front();
				if (dout_ch.found !== want.found || dout_ch.match_start !== want.match_start
					|| dout_ch.bad_needle !== want.bad_needle) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected found %0b start %0d bad %0b, got %0b %0d %0b",
							want.found, want.match_start, want.bad_needle,
							dout_ch.found, dout_ch.match_start, dout_ch.bad_needle);
				end
			end
		end
	end

	// Watchdog on cycles without any transfer.
	always @(posedge clk) begin
		if ((din_ch.valid && din_ch.ready) || (dout_ch.valid && dout_ch.ready)) begin
			stall_count <= 0;
		end else if (stall_count >= STALL_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end else begin
			stall_count <= stall_count + 1;
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_BASE;
		cfg_data = '0;
		din_ch.valid = 1'b0;
		din_ch.action = ACT_LOAD;
		din_ch.data_byte = '0;
		din_ch.first_byte = 1'b0;
		din_ch.last_byte = 1'b0;
		base_r = BASE_RESET;
		mod_r = MODULUS_RESET;
		pat_len = 0;
		pat_over = 0;
		pat_hash = '0;
		pat_pow = 1;
		win_hash = '0;
		pos_cnt = '0;
		done_flag = 0;
		mismatches = 0;
		tx_idle_on = 1;
		rx_idle_on = 1;
		rx_hold_req = 0;
		stall_count = 0;
		random_sent = 0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_empty_needle();
		test_basic_search();
		test_long_needle();
		test_register_extremes();
		test_backpressure();
		test_random_searches();

		if (mismatches == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

// ----- files.f -----
rtl/core/rkvs_pkg.sv
rtl/core/rkvs_if.sv
rtl/core/rkvs_ram.sv
rtl/core/rabin_karp_verified_search.sv
tb/rabin_karp_verified_search_tb.sv
